// File: design/piecewise_linear_interpolator_core_assert.svh
// Assertion macros for the piecewise linear interpolator.
// Included by the core top level, which checks its own sequencing; no other dependencies.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PLI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pli: same-cycle check failed");
// next-cycle implication
`define PLI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pli: next-cycle check failed");
`else
`define PLI_ASSERT_IMP(label, clk, rst, ante, cons)
`define PLI_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/pli_pkg.sv
// Shared types and codes for the piecewise linear interpolator.
// No dependencies; used by the divider, the top level and the bench.
package pli_pkg;

   // request kind carried in req_tuser
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } pli_div_status_type;

endpackage

// File: design/pli_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pli_pkg for the status struct.
module pli_divider #(
   parameter int DIVIDEND_BITS = 49,
   parameter int DIVISOR_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_BITS-1:0]      dividend,
   input  logic [DIVISOR_BITS-1:0]       divisor,
   output pli_pkg::pli_div_status_type   status,
   output logic [DIVIDEND_BITS-1:0]      quotient
);
   import pli_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;

   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    trial;
   logic                     fits;

   // one restoring step: bring in the next dividend bit, try to subtract
   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = ~trial[DIVISOR_BITS];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_BITS);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// File: design/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator: breakpoint table, binary search, shared multiplier
// and serial divider. Depends on pli_pkg, pli_divider and the assertion header.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  req     | in        | req_tvalid/req_tready  | tdata: index, position, value, query
//          |           |                        | tuser: op
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: interpolated_value
//          |           |                        | tuser: in_range
//  csr     | in        | csr_valid/csr_ready    | csr_data: nodes_in_use
//
// A load is written into the table when it is accepted. A query steps through S_FIRST,
// S_LAST, a binary search of at most ceil(log2(n-1)) steps over a one-read table port,
// S_WEIGHTS, S_MUL_LO, S_MUL_HI, S_SUM, S_DIVIDE and S_FINISH; the serial divider
// dominates. Queries outside the table end after S_FIRST or S_LAST, a zero-width segment
// after S_MUL_LO. req_tready is high only while the sequencer is idle; a finished result
// waits in the output register, and a new query stalls at its end until that register is
// taken. Reset is synchronous; the table holds no reset value.
`include "piecewise_linear_interpolator_core_assert.svh"

module piecewise_linear_interpolator_core #(
   parameter int MAX_NODES     = 16,
   parameter int POSITION_BITS = 16,
   parameter int VALUE_BITS    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // node_index, node_position, node_value, query_position (lowest bit up), zero padded
   input  logic [((($clog2(MAX_NODES) + 3 * POSITION_BITS + VALUE_BITS) + 7) / 8) * 8 - 1:0]
                                req_tdata,
   // op
   input  logic                 req_tuser,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // interpolated_value, zero padded
   output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // in_range
   output logic                 rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [4:0]           csr_data
);
   import pli_pkg::*;

   localparam int IDX_W   = $clog2(MAX_NODES);
   localparam int CNT_W   = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
   localparam int PROD_W  = VALUE_BITS + POSITION_BITS;
   localparam int SUM_W   = PROD_W + 1;
   localparam int RSP_W   = ((VALUE_BITS + 7) / 8) * 8;
   localparam int POS_LSB = IDX_W;
   localparam int VAL_LSB = IDX_W + POSITION_BITS;
   localparam int QRY_LSB = IDX_W + POSITION_BITS + VALUE_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_LAST, S_SEARCH, S_WEIGHTS,
      S_MUL_LO, S_MUL_HI, S_SUM, S_DIVIDE, S_FINISH
   } state_type;

   // request fields
   logic [IDX_W-1:0]         req_index;
   logic [POSITION_BITS-1:0] req_position;
   logic [VALUE_BITS-1:0]    req_value;
   logic [POSITION_BITS-1:0] req_query;
   logic                     req_accept;

   assign req_index    = req_tdata[IDX_W-1:0];
   assign req_position = req_tdata[POS_LSB +: POSITION_BITS];
   assign req_value    = req_tdata[VAL_LSB +: VALUE_BITS];
   assign req_query    = req_tdata[QRY_LSB +: POSITION_BITS];
   assign req_accept   = req_tvalid & req_tready;

   // configuration register
   logic [4:0] nodes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff <= 5'd2;
      end else if (csr_valid & csr_ready) begin
         nodes_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // clamp node count and take the index of the last breakpoint in use
   logic [CNT_W-1:0] n_wide;
   logic [CNT_W-1:0] n_eff;
   logic [IDX_W-1:0] n_last;

   always_comb begin
      n_wide = CNT_W'(nodes_ff);
      n_eff  = n_wide;
      if (n_wide < CNT_W'(2)) begin
         n_eff = CNT_W'(2);
      end else if (n_wide > CNT_W'(MAX_NODES)) begin
         n_eff = CNT_W'(MAX_NODES);
      end
      n_last = IDX_W'(n_eff - CNT_W'(1));
   end

   // breakpoint table: one write port, one registered read port
   logic [POSITION_BITS-1:0] pos_mem_ff [MAX_NODES];
   logic [VALUE_BITS-1:0]    val_mem_ff [MAX_NODES];
   logic [POSITION_BITS-1:0] pos_rd_ff;
   logic [VALUE_BITS-1:0]    val_rd_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;

   assign mem_we = req_accept & (req_tuser == OP_LOAD)
                   & ({1'b0, req_index} < (IDX_W + 1)'(MAX_NODES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem_ff[req_index] <= req_position;
         val_mem_ff[req_index] <= req_value;
      end
      pos_rd_ff <= pos_mem_ff[rd_addr];
      val_rd_ff <= val_mem_ff[rd_addr];
   end

   // sequencer registers
   state_type                state_ff, state_in;
   logic [POSITION_BITS-1:0] q_ff, q_in;
   logic [POSITION_BITS-1:0] plo_ff, plo_in;
   logic [POSITION_BITS-1:0] phi_ff, phi_in;
   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic [POSITION_BITS-1:0] wlo_ff, wlo_in;
   logic [POSITION_BITS-1:0] whi_ff, whi_in;
   logic [POSITION_BITS-1:0] width_ff, width_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [VALUE_BITS-1:0]    res_val_ff, res_val_in;
   logic                     res_ok_ff, res_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_val_ff, rsp_val_in;
   logic                     rsp_ok_ff, rsp_ok_in;

   // shared multiplier and comparators
   logic [POSITION_BITS-1:0] mul_b;
   logic [PROD_W-1:0]        mul_out;
   logic                     pos_lt_q;
   logic                     q_lt_pos;
   logic [IDX_W:0]           span_sum;
   logic [IDX_W-1:0]         lo_n, hi_n;

   assign mul_b    = (state_ff == S_MUL_LO) ? wlo_ff : whi_ff;
   assign mul_out  = PROD_W'(val_rd_ff) * PROD_W'(mul_b);
   assign pos_lt_q = pos_rd_ff < q_ff;
   assign q_lt_pos = q_ff < pos_rd_ff;

   // divider
   logic               div_start;
   logic [SUM_W-1:0]   div_dividend;
   logic [SUM_W-1:0]   div_quotient;
   pli_div_status_type div_status;

   assign div_start    = (state_ff == S_SUM);
   assign div_dividend = {1'b0, acc_ff} + {1'b0, prod_ff};

   pli_divider #(
      .DIVIDEND_BITS (SUM_W),
      .DIVISOR_BITS  (POSITION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (width_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      wlo_in       = wlo_ff;
      whi_in       = whi_ff;
      width_in     = width_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      res_val_in   = res_val_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_ok_in    = rsp_ok_ff;
      rd_addr      = lo_ff;
      lo_n         = lo_ff;
      hi_n         = hi_ff;
      span_sum     = '0;

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_accept && (req_tuser == OP_QUERY)) begin
               q_in     = req_query;
               state_in = S_FIRST;
            end
         end
         // first breakpoint arrives; fetch the last one in use
         S_FIRST: begin
            rd_addr = n_last;
            plo_in  = pos_rd_ff;
            lo_in   = '0;
            if (q_lt_pos) begin
               res_val_in = '0;
               res_ok_in  = 1'b0;
               state_in   = S_FINISH;
            end else begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            phi_in   = pos_rd_ff;
            hi_in    = n_last;
            mid_in   = n_last >> 1;
            rd_addr  = n_last >> 1;
            if (!q_lt_pos) begin
               res_val_in = '0;
               res_ok_in  = 1'b0;
               state_in   = S_FINISH;
            end else if (n_last > IDX_W'(1)) begin
               state_in = S_SEARCH;
            end else begin
               state_in = S_WEIGHTS;
            end
         end
         // one halving step per cycle
         S_SEARCH: begin
            if (pos_lt_q) begin
               lo_n   = mid_ff;
               plo_in = pos_rd_ff;
            end else begin
               hi_n   = mid_ff;
               phi_in = pos_rd_ff;
            end
            lo_in    = lo_n;
            hi_in    = hi_n;
            span_sum = {1'b0, lo_n} + {1'b0, hi_n};
            mid_in   = span_sum[IDX_W:1];
            rd_addr  = span_sum[IDX_W:1];
            if ((hi_n - lo_n) <= IDX_W'(1)) begin
               rd_addr  = lo_n;
               state_in = S_WEIGHTS;
            end
         end
         S_WEIGHTS: begin
            rd_addr  = lo_ff;
            wlo_in   = phi_ff - q_ff;
            whi_in   = q_ff - plo_ff;
            width_in = phi_ff - plo_ff;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            rd_addr = hi_ff;
            prod_in = mul_out;
            if (width_ff == '0) begin
               res_val_in = '0;
               res_ok_in  = 1'b0;
               state_in   = S_FINISH;
            end else begin
               state_in = S_MUL_HI;
            end
         end
         S_MUL_HI: begin
            prod_in  = mul_out;
            acc_in   = prod_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               res_val_in = div_quotient[VALUE_BITS-1:0];
               res_ok_in  = 1'b1;
               state_in   = S_FINISH;
            end
         end
         // hand over to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff       <= q_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      wlo_ff     <= wlo_in;
      whi_ff     <= whi_in;
      width_ff   <= width_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      res_val_ff <= res_val_in;
      res_ok_ff  <= res_ok_in;
      rsp_val_ff <= rsp_val_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_val_ff);
   assign rsp_tuser  = rsp_ok_ff;

   // checks on the sequencer
   `PLI_ASSERT_IMP(a_done_in_divide, clock, reset, div_status.done, state_ff == S_DIVIDE)
   `PLI_ASSERT_IMP(a_search_span, clock, reset, state_ff == S_SEARCH,
                   (hi_ff - lo_ff) > IDX_W'(1))
   `PLI_ASSERT_IMP(a_divisor_nonzero, clock, reset, div_start, width_ff != '0)
   `PLI_ASSERT_IMP(a_out_of_range_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff,
                   rsp_val_ff == '0)
   `PLI_ASSERT_NXT(a_divider_idle_start, clock, reset, state_ff == S_SUM, div_status.busy)

endmodule

// File: bench/pli_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the piecewise linear interpolator: watches the request, result and
// register channels, predicts every query from its own breakpoint table and compares.
// Depends on pli_pkg for the request kinds.
module pli_result_checker #(
   parameter int REQ_BITS = 88
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [REQ_BITS-1:0] req_tdata,
   input  logic                req_tuser,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [31:0]         rsp_tdata,
   input  logic                rsp_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [4:0]          csr_data,
   output int                  mismatch_count,
   output int                  pending_count
);
   import pli_pkg::*;

   localparam int NODES = 16;

   typedef struct packed {
      logic [31:0] value;
      logic        in_range;
   } interp_result_type;

   // own copy of the breakpoint table and the node count register
   logic [15:0]       bp_pos [NODES];
   logic [31:0]       bp_val [NODES];
   logic [4:0]        node_setting;
   interp_result_type expected_results [$];

   // value at query position q: bounds check, binary search, weighted sum over width
   function automatic interp_result_type interpolate_at(input logic [15:0] q);
      int unsigned       n, lo, hi, mid;
      logic [63:0]       w_lo, w_hi, width, weighted;
      interp_result_type r;
      if (node_setting < 5'd2) n = 2;
      else if (node_setting > NODES) n = NODES;
      else n = node_setting;
      r = '0;
      if (q < bp_pos[0] || q >= bp_pos[n - 1]) return r;
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (bp_pos[mid] < q) lo = mid;
         else hi = mid;
      end
      w_lo  = 64'(bp_pos[hi]) - 64'(q);
      w_hi  = 64'(q) - 64'(bp_pos[lo]);
      width = w_lo + w_hi;
      // zero-width segment answers like a miss
      if (width == 0) return r;
      weighted   = 64'(bp_val[lo]) * w_lo + 64'(bp_val[hi]) * w_hi;
      r.value    = 32'(weighted / width);
      r.in_range = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      interp_result_type got, want;
      int                errs;
      errs = 0;
      if (reset) begin
         expected_results.delete();
         node_setting = 5'd2;
         for (int k = 0; k < NODES; k++) begin
            bp_pos[k] = '0;
            bp_val[k] = '0;
         end
      end else begin
         // results first: an answer never belongs to a query taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.value    = rsp_tdata[31:0];
            got.in_range = rsp_tuser;
            if (expected_results.size() == 0) begin
               $error("result transaction with none expected: interpolated_value %0h in_range %0b",
                      got.value, got.in_range);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (got.value !== want.value) begin
                  $error("interpolated_value: expected %0h, actual %0h", want.value, got.value);
                  errs++;
               end
               if (got.in_range !== want.in_range) begin
                  $error("in_range: expected %0b, actual %0b", want.in_range, got.in_range);
                  errs++;
               end
            end
         end
         if (csr_valid && csr_ready) node_setting = csr_data;
         // request fields from bit 0: index, node position, node value, query position
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_LOAD) begin
               bp_pos[req_tdata[3:0]] = req_tdata[19:4];
               bp_val[req_tdata[3:0]] = req_tdata[51:20];
            end else begin
               expected_results.insert(expected_results.size(),
                                       interpolate_at(req_tdata[67:52]));
            end
         end
      end
      mismatch_count <= mismatch_count + errs;
      pending_count  <= expected_results.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Testbench top for piecewise_linear_interpolator_core: clock, reset, node count writes and
// request stimulus with random idling on both sides; pli_result_checker does the comparing.
// Depends on pli_pkg, the core and the checker.
module tb;
   import pli_pkg::*;

   localparam int REQ_BITS      = (((4 + 3 * 16 + 32) + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int ITEM_TARGET   = 1600;
   // node counts for the first phases, lowest five bits first
   localparam logic [39:0] COUNT_SWEEP =
      {5'd9, 5'd3, 5'd17, 5'd31, 5'd2, 5'd1, 5'd0, 5'd16};

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic [REQ_BITS-1:0] req_tdata  = '0;
   logic                req_tuser  = OP_LOAD;
   logic                req_tvalid = 1'b0;
   logic                rsp_tready = 1'b0;
   logic                csr_valid  = 1'b0;
   logic [4:0]          csr_data   = 5'd0;
   wire                 req_tready;
   wire  [31:0]         rsp_tdata;
   wire                 rsp_tuser;
   wire                 rsp_tvalid;
   wire                 csr_ready;
   int                  mismatch_count;
   int                  pending_count;

   bit                  steady = 1'b0;
   int                  items_sent = 0;
   logic [15:0]         shadow_pos [16];
   logic [4:0]          shadow_setting = 5'd2;

   piecewise_linear_interpolator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   pli_result_checker #(.REQ_BITS(REQ_BITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side back-pressure, off during the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 21);
   end

   // one request transaction; called at a clock edge, returns at the accepting edge
   task automatic drive_request(input logic op, input logic [3:0] idx,
                                input logic [15:0] npos, input logic [31:0] nval,
                                input logic [15:0] qpos);
      // now and then a long gap, so that idle time lands anywhere in a query
      if (!steady && $urandom_range(0, 49) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 70)) @(posedge clock);
      end
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_BITS'({qpos, nval, npos, idx});
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_load(input logic [3:0] idx, input logic [15:0] pos,
                            input logic [31:0] val);
      shadow_pos[idx] = pos;
      drive_request(OP_LOAD, idx, pos, val, 16'($urandom()));
   endtask

   task automatic send_query(input logic [15:0] q);
      drive_request(OP_QUERY, 4'($urandom()), 16'($urandom()), $urandom(), q);
   endtask

   // node count write, only once the core has drained
   task automatic write_setting(input logic [4:0] v);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_setting = v;
   endtask

   // fresh table: spread, full span, crowded with duplicates, or unsorted
   task automatic load_table();
      int          mode, pick;
      logic [15:0] p;
      logic [31:0] v;
      mode = $urandom_range(0, 99);
      if (mode < 50) p = 16'($urandom_range(0, 255));
      else if (mode < 65) p = 16'd0;
      else p = 16'($urandom_range(0, 16'hFF00));
      for (int k = 0; k < 16; k++) begin
         if (mode >= 80) p = 16'($urandom());
         else if (k > 0) begin
            if (mode < 50) p = p + 16'($urandom_range(1, 4352));
            else if (mode < 65) p = (k == 15) ? 16'hFFFF : p + 16'($urandom_range(1, 4369));
            else p = p + 16'($urandom_range(0, 3));
         end
         pick = $urandom_range(0, 9);
         v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
         send_load(4'(k), p, v);
      end
   endtask

   initial begin
      int          r, k, n;
      logic [4:0]  setting;
      logic [15:0] lo_bound, hi_bound, q;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two nodes after reset: full value swing across the table edges
      send_load(4'd0, 16'h0080, 32'hFFFF_FFFF);
      send_load(4'd1, 16'hFFFF, 32'h0000_0000);
      send_query(16'h0000);
      send_query(16'h0080);
      send_query(16'h7FFF);
      send_query(16'hFFFE);
      send_query(16'hFFFF);
      send_load(4'd0, 16'h0000, 32'h0000_0000);
      send_load(4'd1, 16'hFFFF, 32'hFFFF_FFFF);
      send_query(16'h0000);
      send_query(16'hFFFE);

      // three nodes: zero-width first segment, then an unsorted table
      write_setting(5'd3);
      send_load(4'd0, 16'h0100, 32'd5);
      send_load(4'd1, 16'h0100, 32'd7);
      send_load(4'd2, 16'h0200, 32'd9);
      send_query(16'h0100);
      send_query(16'h0180);
      send_load(4'd1, 16'h0300, 32'hFFFF_FFFF);
      send_query(16'h0150);
      send_query(16'h01FF);

      // random phases, each with its own node count and table
      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         setting = (phase < 8) ? COUNT_SWEEP[phase * 5 +: 5] : 5'($urandom_range(0, 31));
         steady <= (phase == 3 || phase == 4);
         write_setting(setting);
         load_table();
         if (shadow_setting < 5'd2) n = 2;
         else if (shadow_setting > 5'd16) n = 16;
         else n = shadow_setting;
         repeat (120) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               // rewrite one node, mostly keeping the order of its neighbours
               k = $urandom_range(0, 15);
               lo_bound = (k == 0) ? 16'h0000 : shadow_pos[k - 1];
               hi_bound = (k == 15) ? 16'hFFFF : shadow_pos[k + 1];
               if ($urandom_range(0, 4) == 0) q = 16'($urandom());
               else q = 16'($urandom_range(lo_bound, hi_bound));
               send_load(4'(k), q, $urandom());
            end else begin
               if (r < 65) begin
                  k = $urandom_range(0, n - 2);
                  q = 16'($urandom_range(shadow_pos[k], shadow_pos[k + 1]));
               end else if (r < 80) begin
                  q = shadow_pos[$urandom_range(0, n - 1)];
               end else begin
                  q = 16'($urandom());
               end
               send_query(q);
            end
         end
      end

      // drain and verdict
      steady <= 1'b0;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
